@@ src/sftd_pkg.sv @@
`default_nettype none
package sftd_pkg;

	localparam logic [7:0] SyncFirst   = 8'hAA;
	localparam logic [7:0] SyncSecond  = 8'h55;
	localparam logic [7:0] SrcLeader   = 8'd2;
	localparam logic [7:0] SrcFollower = 8'd3;
	localparam logic [15:0] JointSkip  = 16'hFFFF;

	localparam int PacketBytes  = 28;
	localparam int PayloadBytes = 24;
	localparam int JointCount   = 6;
	localparam int WordCount    = 3;
	localparam int JointW       = 16;
	localparam int WordW        = 32;
	localparam int PosW         = 5;
	localparam int DataW        = JointCount * JointW + WordCount * WordW;

	localparam logic [PosW-1:0] SrcPos    = PosW'(2);
	localparam logic [PosW-1:0] HeaderPos = PosW'(4);
	localparam logic [PosW-1:0] LastPos   = PosW'(PacketBytes - 1);

	typedef struct packed {
		logic                        done;
		logic                        follower;
		logic [PayloadBytes*8-1:0]   payload;
	} frame_t;

endpackage
`default_nettype wire

@@ src/sftd_framer.sv @@
`default_nettype none
module sftd_framer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  logic [7:0]      rx_byte,
	output sftd_pkg::frame_t frame
);

	logic                      saw_q;
	logic                      inside_q;
	logic [sftd_pkg::PosW-1:0] pos_q;
	logic [7:0]                src_q;
	logic [7:0]                buf_q [sftd_pkg::PayloadBytes];
	logic                      is_last;

	assign is_last = inside_q && (pos_q == sftd_pkg::LastPos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			saw_q    <= 1'b0;
			inside_q <= 1'b0;
			pos_q    <= '0;
		end else if (go) begin
			if (!inside_q) begin
				if (saw_q && rx_byte == sftd_pkg::SyncSecond) begin
					inside_q <= 1'b1;
					pos_q    <= sftd_pkg::SrcPos;
					saw_q    <= 1'b0;
				end else begin
					saw_q <= (rx_byte == sftd_pkg::SyncFirst);
				end
			end else if (is_last) begin
				inside_q <= 1'b0;
				pos_q    <= '0;
				saw_q    <= 1'b0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	// sync bytes inside a packet are plain data
	always_ff @(posedge clk) begin
		if (go && inside_q) begin
			if (pos_q == sftd_pkg::SrcPos)
				src_q <= rx_byte;
			if (pos_q >= sftd_pkg::HeaderPos)
				buf_q[pos_q - sftd_pkg::HeaderPos] <= rx_byte;
		end
	end

	// last payload byte is taken straight from the input register
	always_comb begin
		for (int i = 0; i < sftd_pkg::PayloadBytes - 1; i++)
			frame.payload[i*8 +: 8] = buf_q[i];
		frame.payload[(sftd_pkg::PayloadBytes-1)*8 +: 8] = rx_byte;
		frame.follower = (src_q == sftd_pkg::SrcFollower);
		frame.done     = is_last &&
			(src_q == sftd_pkg::SrcLeader || src_q == sftd_pkg::SrcFollower);
	end

endmodule
`default_nettype wire

@@ src/sftd_store.sv @@
`default_nettype none
module sftd_store (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  sftd_pkg::frame_t           frame,
	output logic                       res_source,
	output logic [sftd_pkg::DataW-1:0] res_data
);

	localparam int WordBase = sftd_pkg::JointCount * sftd_pkg::JointW;

	logic [sftd_pkg::JointW-1:0] lead_q [sftd_pkg::JointCount];
	logic [sftd_pkg::JointW-1:0] fol_q  [sftd_pkg::JointCount];
	logic [sftd_pkg::WordW-1:0]  word_q [sftd_pkg::WordCount];
	logic [sftd_pkg::JointW-1:0] new_j  [sftd_pkg::JointCount];
	logic [sftd_pkg::JointW-1:0] fol_nx [sftd_pkg::JointCount];
	logic [sftd_pkg::WordW-1:0]  new_w  [sftd_pkg::WordCount];

	always_comb begin
		for (int i = 0; i < sftd_pkg::JointCount; i++) begin
			new_j[i]  = frame.payload[i*sftd_pkg::JointW +: sftd_pkg::JointW];
			// follower keeps a joint when the packet marks it as skipped
			fol_nx[i] = (new_j[i] == sftd_pkg::JointSkip) ? fol_q[i] : new_j[i];
		end
		for (int i = 0; i < sftd_pkg::WordCount; i++)
			new_w[i] = frame.payload[WordBase + i*sftd_pkg::WordW +: sftd_pkg::WordW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sftd_pkg::JointCount; i++) begin
				lead_q[i] <= '0;
				fol_q[i]  <= '0;
			end
			for (int i = 0; i < sftd_pkg::WordCount; i++)
				word_q[i] <= '0;
		end else if (load) begin
			if (frame.follower) begin
				for (int i = 0; i < sftd_pkg::JointCount; i++)
					fol_q[i] <= fol_nx[i];
			end else begin
				for (int i = 0; i < sftd_pkg::JointCount; i++)
					lead_q[i] <= new_j[i];
				for (int i = 0; i < sftd_pkg::WordCount; i++)
					word_q[i] <= new_w[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_source <= frame.follower;
			for (int i = 0; i < sftd_pkg::JointCount; i++)
				res_data[i*sftd_pkg::JointW +: sftd_pkg::JointW] <=
					frame.follower ? fol_nx[i] : new_j[i];
			for (int i = 0; i < sftd_pkg::WordCount; i++)
				res_data[WordBase + i*sftd_pkg::WordW +: sftd_pkg::WordW] <=
					frame.follower ? word_q[i] : new_w[i];
		end
	end

endmodule
`default_nettype wire

@@ src/sync_framed_telemetry_deframer.sv @@
// result: m_tvalid is registered and rises once the last byte of a leader or follower
// packet has passed the input register stage; other bytes give no result
// throughput: one byte per cycle, set by the single input register stage; the last
// byte of a leader or follower packet waits there while the previous result is untaken
// reset: arst_n clears the hunt state and all joint and position stores to zero
`default_nettype none
module sync_framed_telemetry_deframer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,  // rx_byte
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [sftd_pkg::DataW-1:0] m_tdata,  // joint_0..joint_5, end_x_bits..end_z_bits
	output logic                       m_tuser   // 1 when source_code is the follower
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             out_valid_q;
	logic             stall;
	logic             go;
	sftd_pkg::frame_t frame;

	assign stall    = valid_s1 && frame.done && out_valid_q;
	assign go       = valid_s1 && !stall;
	assign s_tready = !stall;
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (go && frame.done)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			byte_s1 <= s_tdata;
	end

	sftd_framer u_framer (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.rx_byte (byte_s1),
		.frame   (frame)
	);

	sftd_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (go && frame.done),
		.frame      (frame),
		.res_source (m_tuser),
		.res_data   (m_tdata)
	);

endmodule
`default_nettype wire

@@ src/sftd_checker.sv @@
`default_nettype none
module sftd_checker (
	input wire                       clk,
	input wire                       arst_n,
	input wire                       s_tready,
	input wire                       m_tvalid,
	input wire                       m_tready,
	input wire [sftd_pkg::DataW-1:0] m_tdata,
	input wire                       m_tuser
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// the stall does not look at m_tready, so a taken result is never followed at once by another
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> !m_tvalid)
		else $error("result followed a taken result immediately");

	// input only stalls behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result waiting");

endmodule

bind sync_framed_telemetry_deframer sftd_checker u_sftd_checker (.*);
`default_nettype wire

@@ bench/sync_framed_telemetry_deframer_test.sv @@
`timescale 1ns / 1ps
module sync_framed_telemetry_deframer_test;

	localparam int WordBase = sftd_pkg::JointCount * sftd_pkg::JointW;

	typedef struct packed {
		logic                               drain;  // hold off until nothing is in flight
		logic [7:0]                         rx;
	} rx_req_t;

	typedef struct packed {
		logic                                                   follower;
		logic [sftd_pkg::JointCount-1:0][sftd_pkg::JointW-1:0] joint;
		logic [sftd_pkg::WordCount-1:0][sftd_pkg::WordW-1:0]   word;
	} arm_report_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [7:0]                     s_tdata = 8'h00;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [sftd_pkg::DataW-1:0]     m_tdata;
	logic                           m_tuser;

	rx_req_t              rx_pending_q[$];
	arm_report_t          arm_report_q[$];
	rx_req_t              next_req;
	arm_report_t          want;
	int                   taken = 0;
	int                   frame_bytes = 0;
	int                   mismatches = 0;
	logic                 calm;

	// predictor state
	logic                                                   saw_aa = 1'b0;
	logic                                                   in_frame = 1'b0;
	logic [sftd_pkg::PosW-1:0]                              frame_pos = '0;
	logic [7:0]                                             frame_src = '0;
	logic [sftd_pkg::PayloadBytes*8-1:0]                    frame_payload = '0;
	logic [sftd_pkg::JointCount-1:0][sftd_pkg::JointW-1:0] lead_ticks = '0;
	logic [sftd_pkg::JointCount-1:0][sftd_pkg::JointW-1:0] fol_ticks = '0;
	logic [sftd_pkg::WordCount-1:0][sftd_pkg::WordW-1:0]   pos_words = '0;

	sync_framed_telemetry_deframer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// no random idling on either side through this stretch; a drain still holds the input back
	assign calm = (taken >= 600) && (taken < 1000);

	task automatic consume_rx_byte(input logic [7:0] b);
		arm_report_t r;
		int p;
		logic [sftd_pkg::JointW-1:0] v;
		if (!in_frame) begin
			if (saw_aa && b == sftd_pkg::SyncSecond) begin
				in_frame = 1'b1;
				frame_pos = sftd_pkg::SrcPos;
				saw_aa = 1'b0;
			end else begin
				saw_aa = (b == sftd_pkg::SyncFirst);
			end
		end else begin
			p = frame_pos;
			if (p == sftd_pkg::SrcPos)
				frame_src = b;
			else if (p >= sftd_pkg::HeaderPos)
				frame_payload[8*(p-sftd_pkg::HeaderPos) +: 8] = b;
			if (p == sftd_pkg::LastPos) begin
				in_frame = 1'b0;
				frame_pos = '0;
				saw_aa = 1'b0;
				if (frame_src == sftd_pkg::SrcLeader) begin
					for (int i = 0; i < sftd_pkg::JointCount; i++)
						lead_ticks[i] = frame_payload[sftd_pkg::JointW*i +: sftd_pkg::JointW];
					for (int i = 0; i < sftd_pkg::WordCount; i++)
						pos_words[i] = frame_payload[WordBase + sftd_pkg::WordW*i +: sftd_pkg::WordW];
					r.follower = 1'b0;
					r.joint = lead_ticks;
					r.word = pos_words;
					arm_report_q.push_back(r);
				end else if (frame_src == sftd_pkg::SrcFollower) begin
					for (int i = 0; i < sftd_pkg::JointCount; i++) begin
						v = frame_payload[sftd_pkg::JointW*i +: sftd_pkg::JointW];
						if (v != sftd_pkg::JointSkip)
							fol_ticks[i] = v;
					end
					r.follower = 1'b1;
					r.joint = fol_ticks;
					r.word = pos_words;
					arm_report_q.push_back(r);
				end
			end else begin
				frame_pos = sftd_pkg::PosW'(p + 1);
			end
		end
	endtask

	task automatic push_byte(input logic [7:0] b);
		rx_req_t q;
		q.drain = 1'b0;
		q.rx = b;
		rx_pending_q.push_back(q);
	endtask

	task automatic push_drain();
		rx_req_t q;
		q.drain = 1'b1;
		q.rx = 8'h00;
		rx_pending_q.push_back(q);
	endtask

	task automatic push_packet(input logic [7:0] src, input logic [7:0] kind,
			input logic [sftd_pkg::PayloadBytes*8-1:0] body);
		push_byte(sftd_pkg::SyncFirst);
		push_byte(sftd_pkg::SyncSecond);
		push_byte(src);
		push_byte(kind);
		for (int i = 0; i < sftd_pkg::PayloadBytes; i++)
			push_byte(body[8*i +: 8]);
		frame_bytes += sftd_pkg::PacketBytes;
	endtask

	// byte driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'h00;
		end else begin
			if (s_tvalid && s_tready) begin
				consume_rx_byte(s_tdata);
				taken <= taken + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (rx_pending_q.size() != 0 && rx_pending_q[0].drain) begin
					s_tvalid <= 1'b0;
					if (arm_report_q.size() == 0)
						next_req = rx_pending_q.pop_front();
				end else if (rx_pending_q.size() != 0 &&
						(calm || $urandom_range(0, 99) >= 25)) begin
					next_req = rx_pending_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_req.rx;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (arm_report_q.size() == 0) begin
					$display("%0t: report with none expected, actual tuser %b tdata %h",
						$time, m_tuser, m_tdata);
					mismatches++;
				end else begin
					want = arm_report_q.pop_front();
					if (m_tuser !== want.follower) begin
						$display("%0t: source expected %b actual %b",
							$time, want.follower, m_tuser);
						mismatches++;
					end
					for (int i = 0; i < sftd_pkg::JointCount; i++)
						if (m_tdata[sftd_pkg::JointW*i +: sftd_pkg::JointW] !==
								want.joint[i]) begin
							$display("%0t: joint_%0d expected %h actual %h", $time, i,
								want.joint[i],
								m_tdata[sftd_pkg::JointW*i +: sftd_pkg::JointW]);
							mismatches++;
						end
					for (int i = 0; i < sftd_pkg::WordCount; i++)
						if (m_tdata[WordBase + sftd_pkg::WordW*i +: sftd_pkg::WordW] !==
								want.word[i]) begin
							$display("%0t: position word %0d expected %h actual %h", $time,
								i, want.word[i],
								m_tdata[WordBase + sftd_pkg::WordW*i +: sftd_pkg::WordW]);
							mismatches++;
						end
				end
			end
			m_tready <= calm || ($urandom_range(0, 99) >= 25);
		end
	end

	initial begin : stimulus
		logic [sftd_pkg::PayloadBytes*8-1:0] body;
		logic [7:0] src;
		logic [sftd_pkg::JointW-1:0] jv;
		int sel;
		int n;
		bit drained_a;
		bit drained_b;

		drained_a = 0;
		drained_b = 0;

		// broken and stray sync bytes
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(sftd_pkg::SyncSecond);
		push_byte(sftd_pkg::SyncFirst);
		push_byte(8'h00);
		// repeated first sync byte, leader with every bit set
		push_byte(sftd_pkg::SyncFirst);
		push_packet(sftd_pkg::SrcLeader, 8'h00, '1);
		// follower that skips every joint
		push_packet(sftd_pkg::SrcFollower, 8'hFF, '1);
		// follower with a mix of skips, zero and sync bytes inside the payload
		body = {$urandom, $urandom, $urandom, 16'h55AA, 16'hAA55, sftd_pkg::JointSkip,
			16'h1234, sftd_pkg::JointSkip, 16'h0000};
		push_packet(sftd_pkg::SrcFollower, 8'h5A, body);
		// unknown sources are swallowed whole
		push_packet(8'h00, 8'h00, {6{$urandom}});
		push_packet(8'hFF, sftd_pkg::SyncFirst, {6{$urandom}});
		push_packet(8'h01, 8'h00, {6{$urandom}});
		push_packet(8'h04, 8'h00, {6{$urandom}});
		push_packet(sftd_pkg::SrcLeader, 8'hA5, '0);
		push_drain();

		while (frame_bytes < 1900) begin
			sel = $urandom_range(0, 99);
			if (sel < 75) begin
				n = $urandom_range(0, 99);
				if (n < 40)
					src = sftd_pkg::SrcLeader;
				else if (n < 80)
					src = sftd_pkg::SrcFollower;
				else
					src = 8'($urandom);
				for (int i = 0; i < sftd_pkg::JointCount; i++) begin
					case ($urandom_range(0, 9))
						0, 1, 2: jv = sftd_pkg::JointSkip;
						3:       jv = 16'h0000;
						4:       jv = {sftd_pkg::SyncSecond, sftd_pkg::SyncFirst};
						default: jv = 16'($urandom);
					endcase
					body[sftd_pkg::JointW*i +: sftd_pkg::JointW] = jv;
				end
				for (int i = 0; i < sftd_pkg::WordCount; i++)
					case ($urandom_range(0, 7))
						0:       body[WordBase + sftd_pkg::WordW*i +: sftd_pkg::WordW] = '0;
						1:       body[WordBase + sftd_pkg::WordW*i +: sftd_pkg::WordW] = '1;
						default: body[WordBase + sftd_pkg::WordW*i +: sftd_pkg::WordW] = $urandom;
					endcase
				push_packet(src, 8'($urandom), body);
			end else if (sel < 87) begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					push_byte(8'($urandom));
			end else begin
				case ($urandom_range(0, 2))
					0: begin
						push_byte(sftd_pkg::SyncFirst);
						push_byte(8'($urandom_range(0, 8'h54)));
					end
					1: push_byte(sftd_pkg::SyncSecond);
					default: begin
						push_byte(sftd_pkg::SyncFirst);
						push_byte(sftd_pkg::SyncFirst);
						push_byte(sftd_pkg::SyncFirst);
						push_byte(8'h00);
					end
				endcase
			end
			if (!drained_a && frame_bytes >= 700) begin
				push_drain();
				drained_a = 1;
			end
			if (!drained_b && frame_bytes >= 1400) begin
				push_drain();
				drained_b = 1;
			end
		end

		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (rx_pending_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (arm_report_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatches == 0)
			$display("[sync_framed_telemetry_deframer] OK");
		else
			$display("[sync_framed_telemetry_deframer] ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("[sync_framed_telemetry_deframer] ERROR");
		$finish;
	end

endmodule
